>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	`ASSERT_CLK(lbl, !(expr), msg)

`endif

>>> rtl/core/ttint_pkg.sv
// ----------------------------------------------------------------------------
// Thermistor interpolator package
// Table constants, widths, the point ROM and the types shared by the modules.
// ----------------------------------------------------------------------------
package ttint_pkg;

	localparam int TABLE_POINTS = 15;
	localparam int ADC_BITS     = 12;
	localparam int ROM_SLOTS    = 64;

	// Fixed field widths of the stream beats.
	localparam int READING_W = 12;
	localparam int TENTHS_W  = 11;
	localparam int WHOLE_W   = 8;

	// Points in use and reading width, clamped to their legal ranges.
	localparam int POINTS = (TABLE_POINTS < 2) ? 2 :
		((TABLE_POINTS > ROM_SLOTS) ? ROM_SLOTS : TABLE_POINTS);
	localparam int TOP = POINTS - 1;
	localparam int AW  = (ADC_BITS < 8) ? 8 : ((ADC_BITS > 16) ? 16 : ADC_BITS);
	localparam int RW  = (AW < READING_W) ? AW : READING_W;

	localparam int IDX_W     = $clog2(ROM_SLOTS);
	localparam int ROM_ADC_W = 16;
	localparam int DEG_W     = 8;
	localparam int BASE_W    = DEG_W + 4;
	localparam int SLOPE_W   = DEG_W + 4;
	localparam int NUM_W     = AW + SLOPE_W;
	localparam int QUOT_W    = TENTHS_W;
	localparam int SUM_W     = ((BASE_W > QUOT_W) ? BASE_W : QUOT_W) + 1;

	localparam int DIV_STAGES = 3;
	localparam int DIV_STEPS  = (QUOT_W + DIV_STAGES - 1) / DIV_STAGES;

	localparam int TEN        = 10;
	localparam int TENTHS_MAX = 2 ** TENTHS_W - 1;

	// Division by ten as a multiply by a rounded-up reciprocal; exact for any
	// value that fits in TENTHS_W bits.
	localparam int DIV10_SHIFT = 19;
	localparam int DIV10_MUL   = (2 ** DIV10_SHIFT + TEN - 1) / TEN;
	localparam int DIV10_MUL_W = $clog2(DIV10_MUL + 1);
	localparam int DIV10_PROD_W = TENTHS_W + DIV10_MUL_W;

	typedef struct packed {
		logic [ROM_ADC_W-1:0] adc;
		logic [DEG_W-1:0]     deg;
	} tab_point_t;

	// Per-item segment information that rides beside the divider.
	typedef struct packed {
		logic [BASE_W-1:0] base;
		logic              zero_w;
		logic              below;
		logic              above;
	} seg_t;

	// Point ROM: rising converter codes against whole degrees. Unlisted slots
	// read as zero.
	function automatic tab_point_t rom_point(input logic [IDX_W-1:0] idx);
		tab_point_t p;
		unique case (idx)
			IDX_W'(0):  p = '{adc: 16'd90,   deg: 8'd25};
			IDX_W'(1):  p = '{adc: 16'd110,  deg: 8'd30};
			IDX_W'(2):  p = '{adc: 16'd160,  deg: 8'd40};
			IDX_W'(3):  p = '{adc: 16'd230,  deg: 8'd50};
			IDX_W'(4):  p = '{adc: 16'd300,  deg: 8'd60};
			IDX_W'(5):  p = '{adc: 16'd390,  deg: 8'd70};
			IDX_W'(6):  p = '{adc: 16'd470,  deg: 8'd80};
			IDX_W'(7):  p = '{adc: 16'd560,  deg: 8'd90};
			IDX_W'(8):  p = '{adc: 16'd640,  deg: 8'd100};
			IDX_W'(9):  p = '{adc: 16'd710,  deg: 8'd110};
			IDX_W'(10): p = '{adc: 16'd790,  deg: 8'd120};
			IDX_W'(11): p = '{adc: 16'd870,  deg: 8'd130};
			IDX_W'(12): p = '{adc: 16'd950,  deg: 8'd140};
			IDX_W'(13): p = '{adc: 16'd1030, deg: 8'd150};
			IDX_W'(14): p = '{adc: 16'd1110, deg: 8'd160};
			default:    p = '0;
		endcase
		return p;
	endfunction

	localparam tab_point_t TOP_POINT = rom_point(IDX_W'(TOP));
	localparam int TOP_BASE   = int'(TOP_POINT.deg) * TEN;
	localparam int TOP_TENTHS = (TOP_BASE > TENTHS_MAX) ? TENTHS_MAX : TOP_BASE;

endpackage

>>> rtl/core/ttint_div.sv
// ----------------------------------------------------------------------------
// Pipelined segment divider
// Restoring unsigned divide over three register stages with an overflow flag.
// ----------------------------------------------------------------------------
module ttint_div
	import ttint_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [ROM_ADC_W-1:0] den,
	input  seg_t              tag_in,
	output logic              out_valid,
	output logic [QUOT_W-1:0] quot,
	output logic              ovf,
	output seg_t              tag_out
);

	typedef struct packed {
		logic [NUM_W-1:0]  rem;
		logic [QUOT_W-1:0] quot;
	} div_part_t;

	// Resolves up to DIV_STEPS quotient bits, highest first. The remainder is
	// known to be below den shifted one past the first bit.
	function automatic div_part_t div_steps(input div_part_t a, input logic [NUM_W-1:0] d,
			input int first);
		div_part_t r;
		int b;
		r = a;
		for (int s = 0; s < DIV_STEPS; s++) begin
			b = first - s;
			if (b >= 0) begin
				if ((r.rem >> b) >= d) begin
					r.rem     = r.rem - (d << b);
					r.quot[b] = 1'b1;
				end
			end
		end
		return r;
	endfunction

	logic [NUM_W-1:0] den_w;
	div_part_t        part_in, part1, part2, part3;
	logic             ovf_in;

	logic             v_s1, v_s2, v_s3;
	div_part_t        part_s1, part_s2, part_s3;
	logic [NUM_W-1:0] den_s1, den_s2;
	logic             ovf_s1, ovf_s2, ovf_s3;
	seg_t             tag_s1, tag_s2, tag_s3;

	always_comb begin
		den_w   = NUM_W'(den);
		ovf_in  = (num >> QUOT_W) >= den_w;
		part_in = '{rem: num, quot: '0};
		part1   = div_steps(part_in, den_w, QUOT_W - 1);
		part2   = div_steps(part_s1, den_s1, QUOT_W - 1 - DIV_STEPS);
		part3   = div_steps(part_s2, den_s2, QUOT_W - 1 - 2 * DIV_STEPS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			part_s1 <= part1;
			den_s1  <= den_w;
			ovf_s1  <= ovf_in;
			tag_s1  <= tag_in;
			part_s2 <= part2;
			den_s2  <= den_s1;
			ovf_s2  <= ovf_s1;
			tag_s2  <= tag_s1;
			part_s3 <= part3;
			ovf_s3  <= ovf_s2;
			tag_s3  <= tag_s2;
		end
	end

	assign out_valid = v_s3;
	assign quot      = part_s3.quot;
	assign ovf       = ovf_s3;
	assign tag_out   = tag_s3;

endmodule

>>> rtl/core/thermistor_table_interpolator.sv
// ----------------------------------------------------------------------------
// Thermistor table interpolator
// Converts converter readings to tenths of a degree by piecewise linear
// interpolation over a fixed point ROM, one beat per cycle while the sink keeps up.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Beat contents
//   s_axis   in         tdata: adc_reading
//   m_axis   out        tdata: temp_tenths, temp_whole; tuser: below_range,
//                       above_range
//
// A new beat may enter every cycle while the output is not held by the sink.
// The pipeline holds the segment search, the slope multiply, the three-stage
// restoring divider and the final divide by ten. Reset clears only the stage
// valid bits; the block keeps no other state. When the output beat is held by
// the sink, the whole pipeline freezes and s_axis_tready drops, so no beat is
// lost or repeated.
//
`include "assert_macros.svh"

module thermistor_table_interpolator
	import ttint_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Input beats.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [11:0] adc_reading, [15:12] zero
	// Output beats.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [10:0] temp_tenths, [18:11] temp_whole,
	                                    // [23:19] zero
	output logic [1:0]  m_axis_tuser    // [0] below_range, [1] above_range
);

	// One enable moves every stage. The pipeline advances whenever the output
	// register is empty or is being emptied this cycle.
	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// Stage 1: capture the reading, keeping only the converter's bits.
	logic                 v_s1;
	logic [AW-1:0]        r_s1;

	// Stage 2: compare the reading against every lower segment point at once.
	logic                 v_s2;
	logic [ROM_ADC_W-1:0] r_s2;
	logic [TOP-1:0]       ge_s2;
	logic                 above_s2;
	logic [TOP-1:0]       ge_c;
	logic [ROM_ADC_W-1:0] r_wide;
	tab_point_t           pt_c;

	// Stage 3: pick the segment and form the divide operands.
	logic                 v_s3;
	logic [AW-1:0]        diff_s3;
	logic [SLOPE_W-1:0]   slope_s3;
	logic [ROM_ADC_W-1:0] den_s3;
	seg_t                 seg_s3;
	logic [IDX_W-1:0]     idx_c;
	logic                 found_c;
	tab_point_t           lo_c, hi_c;
	seg_t                 seg_c;

	// Stage 4: numerator product.
	logic                 v_s4;
	logic [NUM_W-1:0]     num_s4;
	logic [ROM_ADC_W-1:0] den_s4;
	seg_t                 seg_s4;

	// Stages 5 to 7 live in the divider.
	logic                 d_valid;
	logic [QUOT_W-1:0]    d_quot;
	logic                 d_ovf;
	seg_t                 d_seg;

	// Stage 8: add the base, saturate and apply the range cases.
	logic                 v_s8;
	logic [TENTHS_W-1:0]  tenths_s8;
	logic                 below_s8, above_s8;
	logic [SUM_W-1:0]     sum_c;
	logic [TENTHS_W-1:0]  tenths_c;

	// Stage 9: output register with whole degrees.
	logic                 v_s9;
	logic [TENTHS_W-1:0]  tenths_s9;
	logic [WHOLE_W-1:0]   whole_s9;
	logic                 below_s9, above_s9;
	logic [DIV10_PROD_W-1:0] prod10_c;

	always_comb begin
		r_wide = ROM_ADC_W'(r_s1);
		pt_c   = '0;
		for (int i = 0; i < TOP; i++) begin
			pt_c    = rom_point(IDX_W'(i));
			ge_c[i] = r_wide >= pt_c.adc;
		end
	end

	// The highest lower point at or below the reading names the segment.
	always_comb begin
		idx_c   = '0;
		found_c = 1'b0;
		for (int i = 0; i < TOP; i++) begin
			if (ge_s2[i]) begin
				idx_c   = IDX_W'(i);
				found_c = 1'b1;
			end
		end
		lo_c = rom_point(idx_c);
		hi_c = rom_point(idx_c + IDX_W'(1));

		seg_c.above  = above_s2;
		seg_c.below  = !above_s2 && !found_c;
		seg_c.zero_w = (hi_c.adc == lo_c.adc);
		if (above_s2) begin
			seg_c.base = BASE_W'(TOP_BASE);
		end else begin
			seg_c.base = BASE_W'(lo_c.deg) * BASE_W'(TEN);
		end
	end

	always_comb begin
		if (d_seg.below) begin
			tenths_c = '0;
			sum_c    = '0;
		end else begin
			if (d_seg.above || d_seg.zero_w) begin
				sum_c = SUM_W'(d_seg.base);
			end else if (d_ovf) begin
				sum_c = SUM_W'(TENTHS_MAX) + SUM_W'(1);
			end else begin
				sum_c = SUM_W'(d_seg.base) + SUM_W'(d_quot);
			end
			if (sum_c > SUM_W'(TENTHS_MAX)) begin
				tenths_c = TENTHS_W'(TENTHS_MAX);
			end else begin
				tenths_c = sum_c[TENTHS_W-1:0];
			end
		end
	end

	assign prod10_c = DIV10_PROD_W'(tenths_s8) * DIV10_PROD_W'(DIV10_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s8 <= d_valid;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1      <= AW'(s_axis_tdata[RW-1:0]);
			r_s2      <= r_wide;
			ge_s2     <= ge_c;
			above_s2  <= r_wide >= TOP_POINT.adc;
			diff_s3   <= AW'(r_s2 - lo_c.adc);
			slope_s3  <= SLOPE_W'(DEG_W'(hi_c.deg - lo_c.deg)) * SLOPE_W'(TEN);
			den_s3    <= hi_c.adc - lo_c.adc;
			seg_s3    <= seg_c;
			num_s4    <= NUM_W'(diff_s3) * NUM_W'(slope_s3);
			den_s4    <= den_s3;
			seg_s4    <= seg_s3;
			tenths_s8 <= tenths_c;
			below_s8  <= d_seg.below;
			above_s8  <= d_seg.above;
			tenths_s9 <= tenths_s8;
			whole_s9  <= WHOLE_W'(prod10_c >> DIV10_SHIFT);
			below_s9  <= below_s8;
			above_s9  <= above_s8;
		end
	end

	ttint_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.num       (num_s4),
		.den       (den_s4),
		.tag_in    (seg_s4),
		.out_valid (d_valid),
		.quot      (d_quot),
		.ovf       (d_ovf),
		.tag_out   (d_seg)
	);

	assign m_axis_tvalid = v_s9;
	assign m_axis_tdata  = {(24 - TENTHS_W - WHOLE_W)'(0), whole_s9, tenths_s9};
	assign m_axis_tuser  = {above_s9, below_s9};

	// A reading cannot be both under the first point and at the top.
	`ASSERT_NEVER(a_range_excl, v_s9 && below_s9 && above_s9, "both range flags set")

	// Readings under the table report zero in both temperature fields.
	`ASSERT_CLK(a_below_zero, (v_s9 && below_s9) |-> (tenths_s9 == '0 && whole_s9 == '0),
		"below range result not zero")

	// Saturated readings report the top table temperature.
	`ASSERT_CLK(a_above_top, (v_s9 && above_s9) |-> (tenths_s9 == TENTHS_W'(TOP_TENTHS)),
		"above range result not the top temperature")

	// Whole degrees agree with tenths.
	`ASSERT_CLK(a_whole_match, v_s9 |-> ((12'(whole_s9) * 12'd10 <= 12'(tenths_s9)) &&
		(12'(tenths_s9) < 12'(whole_s9) * 12'd10 + 12'd10)), "whole degrees mismatch")

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// Thermistor interpolator testbench
// Streams converter readings into the interpolator and checks every output
// beat against a predictor that walks the same point table, under several
// idle and stall patterns on both stream sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top
	import ttint_pkg::*;
;

	// One predicted or observed temperature beat.
	typedef struct packed {
		logic [TENTHS_W-1:0] tenths;
		logic [WHOLE_W-1:0]  whole;
		logic                below;
		logic                above;
	} temp_result_t;

	// The board's calibration points: rising converter codes against degrees.
	localparam int NPTS = 15;
	localparam int PT_ADC [NPTS] = '{90, 110, 160, 230, 300, 390, 470, 560,
		640, 710, 790, 870, 950, 1030, 1110};
	localparam int PT_DEG [NPTS] = '{25, 30, 40, 50, 60, 70, 80, 90,
		100, 110, 120, 130, 140, 150, 160};
	localparam int CLAMP_TENTHS = 2047;

	// Idle percentages per phase, switched by the number of beats sent.
	localparam int PHASE_LEN   = 490;
	localparam int HOLD_AT     = 400;   // result count that starts the long hold
	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_ITEMS = 1430;

	logic clk;
	logic arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	logic [READING_W-1:0] pending_readings [$];
	temp_result_t         awaited_temps [$];

	int sent_beats;
	int temps_seen;
	int mismatches;
	int n_below;
	int n_above;
	int n_interp;
	int hold_left;
	bit hold_done;

	thermistor_table_interpolator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Piecewise linear conversion of one reading. The segment is chosen by
	// its lower point; the slope term truncates toward zero like an integer
	// divide, and the sum is clamped to what eleven bits can hold.
	function automatic temp_result_t predict_temperature(input logic [READING_W-1:0] rd);
		temp_result_t res;
		int code;
		int seg;
		int acc;
		code = int'(rd);
		res = '0;
		seg = -1;
		if (code >= PT_ADC[NPTS-1]) begin
			acc = PT_DEG[NPTS-1] * 10;
			res.above = 1'b1;
		end else begin
			for (int k = NPTS - 2; k >= 0; k--) begin
				if (seg < 0 && code >= PT_ADC[k])
					seg = k;
			end
			if (seg < 0) begin
				acc = 0;
				res.below = 1'b1;
			end else begin
				acc = PT_DEG[seg] * 10;
				// A segment of zero width contributes no slope term.
				if (PT_ADC[seg+1] > PT_ADC[seg])
					acc += ((code - PT_ADC[seg]) * (PT_DEG[seg+1] - PT_DEG[seg]) * 10) /
						(PT_ADC[seg+1] - PT_ADC[seg]);
			end
		end
		if (acc < 0)
			acc = 0;
		if (acc > CLAMP_TENTHS)
			acc = CLAMP_TENTHS;
		res.tenths = TENTHS_W'(acc);
		res.whole  = WHOLE_W'(acc / 10);
		return res;
	endfunction

	// The first third of the run has a sluggish sink, the second a sluggish
	// source, and the last runs both sides flat out.
	function automatic int send_idle_pct(input int sent);
		if (sent < PHASE_LEN)
			return 17;
		else if (sent < 2 * PHASE_LEN)
			return 79;
		return 0;
	endfunction

	function automatic int recv_idle_pct(input int sent);
		if (sent < PHASE_LEN)
			return 79;
		else if (sent < 2 * PHASE_LEN)
			return 17;
		return 0;
	endfunction

	// Driver. A beat leaves the queue only once the one on the bus has been
	// taken, so tvalid never drops while a beat is still offered.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			sent_beats    <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				awaited_temps.push_back(predict_temperature(s_axis_tdata[READING_W-1:0]));
				sent_beats <= sent_beats + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_readings.size() > 0 &&
						$urandom_range(99) >= send_idle_pct(sent_beats)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {4'b0, pending_readings.pop_front()};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Checks each output beat against the oldest prediction and
	// drives tready, including one long hold-off that backs the pipeline up
	// into the input side.
	always @(posedge clk or negedge arst_n) begin
		temp_result_t got;
		temp_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			temps_seen = 0;
			mismatches = 0;
			n_below    = 0;
			n_above    = 0;
			n_interp   = 0;
			hold_left  = 0;
			hold_done  = 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.tenths = m_axis_tdata[10:0];
				got.whole  = m_axis_tdata[18:11];
				got.below  = m_axis_tuser[0];
				got.above  = m_axis_tuser[1];
				temps_seen++;
				if (awaited_temps.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected beat: tenths=%0d whole=%0d below=%0b above=%0b",
						$time, got.tenths, got.whole, got.below, got.above);
				end else begin
					want = awaited_temps.pop_front();
					if (got.tenths !== want.tenths || got.whole !== want.whole ||
							got.below !== want.below || got.above !== want.above) begin
						mismatches++;
						$write("%0t: mismatch: expected tenths=%0d whole=%0d below=%0b above=%0b,",
							$time, want.tenths, want.whole, want.below, want.above);
						$display(" got tenths=%0d whole=%0d below=%0b above=%0b",
							got.tenths, got.whole, got.below, got.above);
					end
					if (want.below)
						n_below++;
					else if (want.above)
						n_above++;
					else
						n_interp++;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && temps_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct(sent_beats));
			end
		end
	end

	// Wait until everything queued has gone through the block.
	task automatic wait_drained();
		while (pending_readings.size() > 0 || s_axis_tvalid || awaited_temps.size() > 0)
			@(posedge clk);
	endtask

	// Random reading: mostly inside the table, some right at a point's edge,
	// and some across the whole converter range.
	function automatic logic [READING_W-1:0] random_reading();
		int pick;
		int k;
		pick = $urandom_range(99);
		if (pick < 60)
			return READING_W'($urandom_range(1120, 80));
		if (pick < 80) begin
			k = $urandom_range(NPTS - 1);
			return READING_W'(PT_ADC[k] + $urandom_range(2) - 1);
		end
		return READING_W'($urandom_range(4095));
	endfunction

	initial begin
		logic [READING_W-1:0] edge_codes [$];
		edge_codes = '{0, 1, 89, 90, 91, 100, 109, 110, 111, 159, 160, 559, 560,
			1029, 1030, 1109, 1110, 1111, 2730, 1365, 2048, 4095};
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed readings: both table ends, the first segment, points and
		// their neighbors, and alternating bit patterns.
		foreach (edge_codes[k])
			pending_readings.push_back(edge_codes[k]);
		// The source goes quiet until the directed beats have all returned.
		wait_drained();

		for (int k = 0; k < RANDOM_ITEMS / 2; k++)
			pending_readings.push_back(random_reading());
		wait_drained();
		for (int k = RANDOM_ITEMS / 2; k < RANDOM_ITEMS; k++)
			pending_readings.push_back(random_reading());
		wait_drained();

		// Let the pipeline run out in case anything stray is still inside.
		repeat (30) @(posedge clk);
		$display("Checked %0d temperature beats from %0d readings.", temps_seen, sent_beats);
		$display("Below range: %0d, saturated at top: %0d, interpolated: %0d.",
			n_below, n_above, n_interp);
		if (mismatches == 0 && awaited_temps.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin
		#400000;
		$display("Timeout with %0d beats still awaited.", awaited_temps.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
